// ===== hdl/plu_pkg.sv =====
`default_nettype none
package plu_pkg;

  localparam int DT_Q16    = 1311;
  localparam int Q_ONE     = 65536;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 48;
  localparam int QUOT_W    = 41;
  localparam int DEN_W     = 24;
  localparam int DIV_STEPS = 41;

  localparam logic [31:0] NET_ACCEL_RST     = 32'd0;
  localparam logic [23:0] SLOWDOWN_RATE_RST = 24'd0;
  localparam logic [23:0] LIFESPAN_RST      = 24'd655360;
  localparam logic [15:0] RAMP_MID_RST      = 16'd32768;
  localparam logic [47:0] SIZE_POINTS_RST   = 48'h004000400040;
  localparam logic [31:0] COLOR_RST         = 32'hFFFFFFFF;
  localparam logic [40:0] RECIP_LIFE_RST    = 41'd1677721;
  localparam logic [32:0] RECIP_MID_RST     = 33'd131072;
  localparam logic [32:0] RECIP_REST_RST    = 33'd131072;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NET_ACCEL     = 3'd0,
    REG_SLOWDOWN_RATE = 3'd1,
    REG_LIFESPAN      = 3'd2,
    REG_RAMP_MID      = 3'd3,
    REG_SIZE_POINTS   = 3'd4,
    REG_COLOR_START   = 3'd5,
    REG_COLOR_MID     = 3'd6,
    REG_COLOR_END     = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    RS_IDLE,
    RS_LOAD_LIFE,
    RS_DIV_LIFE,
    RS_LOAD_MID,
    RS_DIV_MID,
    RS_LOAD_REST,
    RS_DIV_REST
  } recip_state_t;

  typedef struct packed {
    logic signed [31:0] net_accel;
    logic [23:0]        slowdown_rate;
    logic [23:0]        lifespan;
    logic [15:0]        ramp_mid;
    logic [47:0]        size_points;
    logic [31:0]        color_start;
    logic [31:0]        color_mid;
    logic [31:0]        color_end;
    logic [40:0]        recip_life;
    logic [32:0]        recip_mid;
    logic [32:0]        recip_rest;
  } cfg_t;

  // exp(-x) for x = y / 2^30, by a short series on x/256 and eight squarings
  function automatic logic [16:0] exp_entry(input logic [63:0] y);
    logic [63:0] r;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] e;
    r    = y >> 8;
    term = 64'd1 << 30;
    sum  = term;
    term = (term * r + (64'd1 << 29)) >> 30;
    sum  = sum - term;
    term = ((term * r + (64'd1 << 29)) >> 30) / 2;
    sum  = sum + term;
    term = ((term * r + (64'd1 << 29)) >> 30) / 3;
    sum  = sum - term;
    term = ((term * r + (64'd1 << 29)) >> 30) / 4;
    sum  = sum + term;
    term = ((term * r + (64'd1 << 29)) >> 30) / 5;
    sum  = sum - term;
    term = ((term * r + (64'd1 << 29)) >> 30) / 6;
    sum  = sum + term;
    e = sum;
    for (int n = 0; n < 8; n++) begin
      e = (e * e + (64'd1 << 29)) >> 30;
    end
    return 17'((e + (64'd1 << 13)) >> 14);
  endfunction

endpackage
`default_nettype wire

// ===== hdl/plu_if.sv =====
`default_nettype none
interface plu_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] vel_z;
  logic [23:0]        age;

  modport source (output valid, output pos_x, output pos_y, output pos_z, output vel_z,
                  output age, input ready);
  modport sink (input valid, input pos_x, input pos_y, input pos_z, input vel_z,
                input age, output ready);
endinterface

interface plu_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] new_pos_x;
  logic signed [31:0] new_pos_y;
  logic signed [31:0] new_pos_z;
  logic signed [31:0] new_vel_z;
  logic [23:0]        new_age;
  logic [15:0]        size;
  logic [7:0]         red;
  logic [7:0]         green;
  logic [7:0]         blue;
  logic [7:0]         alpha;
  logic               alive;

  modport source (output valid, output new_pos_x, output new_pos_y, output new_pos_z,
                  output new_vel_z, output new_age, output size, output red, output green,
                  output blue, output alpha, output alive, input ready);
  modport sink (input valid, input new_pos_x, input new_pos_y, input new_pos_z,
                input new_vel_z, input new_age, input size, input red, input green,
                input blue, input alpha, input alive, output ready);
endinterface
`default_nettype wire

// ===== hdl/particle_lifetime_update_core.sv =====
// Particle update pipeline: one particle word per clock on the input channel while
// in_ch.ready is high; the output register lets the pipeline keep filling while a result
// waits, and bubbles close up under backpressure. Position and velocity are Q16.16, age
// and lifespan Q8.16, over a fixed step of 0.02 s. Writing lifespan or ramp_mid recomputes
// three reciprocals on a shared restoring divider at one quotient bit per cycle, so
// in_ch.ready stays low until all three are done; other registers take effect on the next
// word. EXP_TABLE_DEPTH sets the size of the damping table, filled at elaboration.
`default_nettype none
module particle_lifetime_update_core import plu_pkg::*; #(
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  plu_in_if.sink                in_ch,
  plu_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg;
  logic busy;

  plu_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .cfg      (cfg),
    .busy     (busy)
  );

  plu_pipe #(
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_pipe (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .busy   (busy),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire

// ===== hdl/plu_recip.sv =====
`default_nettype none
module plu_recip import plu_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              long_num,
  input  logic [DEN_W-1:0]  divisor,
  output logic              busy,
  output logic [QUOT_W-1:0] quot
);

  logic [DEN_W-1:0]  den_r;
  logic [DEN_W-1:0]  rem_r;
  logic [QUOT_W-1:0] num_r;
  logic [QUOT_W-1:0] q_r;
  logic [5:0]        cnt_r;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              ge;

  assign trial = {rem_r, num_r[QUOT_W-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};
  assign busy  = cnt_r != 6'd0;
  assign quot  = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 6'd0;
    end else if (start) begin
      cnt_r <= 6'(DIV_STEPS);
    end else if (busy) begin
      cnt_r <= cnt_r - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= divisor;
      rem_r <= '0;
      q_r   <= '0;
      num_r <= long_num ? (QUOT_W'(1) << 40) : (QUOT_W'(1) << 32);
    end else if (busy) begin
      rem_r <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      num_r <= num_r << 1;
      q_r   <= {q_r[QUOT_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire

// ===== hdl/plu_cfg.sv =====
`default_nettype none
module plu_cfg import plu_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg,
  output logic                  busy
);

  logic signed [31:0] net_accel_r;
  logic [23:0]        slowdown_rate_r;
  logic [23:0]        lifespan_r;
  logic [15:0]        ramp_mid_r;
  logic [47:0]        size_points_r;
  logic [31:0]        color_start_r;
  logic [31:0]        color_mid_r;
  logic [31:0]        color_end_r;
  logic [40:0]        recip_life_r;
  logic [32:0]        recip_mid_r;
  logic [32:0]        recip_rest_r;

  recip_state_t      state_r, state_nxt;
  logic              div_start;
  logic              div_long;
  logic [DEN_W-1:0]  div_den;
  logic              div_busy;
  logic [QUOT_W-1:0] div_quot;
  logic              recalc;
  cfg_reg_t          widx;

  assign widx   = cfg_reg_t'(cfg_idx);
  assign recalc = cfg_we && (widx == REG_LIFESPAN || widx == REG_RAMP_MID);
  assign busy   = state_r != RS_IDLE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      net_accel_r     <= NET_ACCEL_RST;
      slowdown_rate_r <= SLOWDOWN_RATE_RST;
      lifespan_r      <= LIFESPAN_RST;
      ramp_mid_r      <= RAMP_MID_RST;
      size_points_r   <= SIZE_POINTS_RST;
      color_start_r   <= COLOR_RST;
      color_mid_r     <= COLOR_RST;
      color_end_r     <= COLOR_RST;
    end else if (cfg_we) begin
      case (widx)
        REG_NET_ACCEL:     net_accel_r     <= cfg_data[31:0];
        REG_SLOWDOWN_RATE: slowdown_rate_r <= cfg_data[23:0];
        REG_LIFESPAN:      lifespan_r      <= cfg_data[23:0];
        REG_RAMP_MID:      ramp_mid_r      <= cfg_data[15:0];
        REG_SIZE_POINTS:   size_points_r   <= cfg_data[47:0];
        REG_COLOR_START:   color_start_r   <= cfg_data[31:0];
        REG_COLOR_MID:     color_mid_r     <= cfg_data[31:0];
        REG_COLOR_END:     color_end_r     <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= RS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    div_long  = 1'b0;
    div_den   = '0;
    case (state_r)
      RS_IDLE: ;
      RS_LOAD_LIFE: begin
        div_start = 1'b1;
        div_long  = 1'b1;
        div_den   = (lifespan_r == 24'd0) ? DEN_W'(1) : lifespan_r;
        state_nxt = RS_DIV_LIFE;
      end
      RS_DIV_LIFE: begin
        if (!div_busy) state_nxt = RS_LOAD_MID;
      end
      RS_LOAD_MID: begin
        div_start = 1'b1;
        div_den   = (ramp_mid_r == 16'd0) ? DEN_W'(1) : DEN_W'(ramp_mid_r);
        state_nxt = RS_DIV_MID;
      end
      RS_DIV_MID: begin
        if (!div_busy) state_nxt = RS_LOAD_REST;
      end
      RS_LOAD_REST: begin
        div_start = 1'b1;
        div_den   = DEN_W'(25'(Q_ONE) - 25'(ramp_mid_r));
        state_nxt = RS_DIV_REST;
      end
      RS_DIV_REST: begin
        if (!div_busy) state_nxt = RS_IDLE;
      end
      default: state_nxt = RS_IDLE;
    endcase
    if (recalc) state_nxt = RS_LOAD_LIFE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recip_life_r <= RECIP_LIFE_RST;
      recip_mid_r  <= RECIP_MID_RST;
      recip_rest_r <= RECIP_REST_RST;
    end else if (!div_busy) begin
      if (state_r == RS_DIV_LIFE) recip_life_r <= div_quot;
      if (state_r == RS_DIV_MID)  recip_mid_r  <= div_quot[32:0];
      if (state_r == RS_DIV_REST) recip_rest_r <= div_quot[32:0];
    end
  end

  plu_recip u_recip (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .long_num (div_long),
    .divisor  (div_den),
    .busy     (div_busy),
    .quot     (div_quot)
  );

  assign cfg = '{
    net_accel:     net_accel_r,
    slowdown_rate: slowdown_rate_r,
    lifespan:      lifespan_r,
    ramp_mid:      ramp_mid_r,
    size_points:   size_points_r,
    color_start:   color_start_r,
    color_mid:     color_mid_r,
    color_end:     color_end_r,
    recip_life:    recip_life_r,
    recip_mid:     recip_mid_r,
    recip_rest:    recip_rest_r
  };

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy || recalc || state_r == RS_LOAD_LIFE)
    else $error("divider restarted mid-run");
  a_busy_run: assert property (@(posedge clk) disable iff (!rst_n)
    div_start && !recalc |=> div_busy && busy)
    else $error("divider did not start");
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == RS_IDLE |-> !div_start)
    else $error("divider started while idle");
`endif

endmodule
`default_nettype wire

// ===== hdl/plu_pipe.sv =====
`default_nettype none
module plu_pipe import plu_pkg::*; #(
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       busy,
  plu_in_if.sink     in_ch,
  plu_out_if.source  out_ch
);

  localparam int IDX_W = $clog2(EXP_TABLE_DEPTH);
  localparam int KX_W  = 49 + $clog2(EXP_TABLE_DEPTH);
  localparam logic [KX_W-1:0] K_HALF  = KX_W'(64'd1 << 35);
  localparam logic [KX_W-1:0] K_DEPTH = KX_W'(EXP_TABLE_DEPTH);

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'h7FFFFFFF;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  logic [16:0] exp_rom [EXP_TABLE_DEPTH];

  for (genvar k = 0; k < EXP_TABLE_DEPTH; k++) begin : g_exp
    localparam logic [63:0] Y = ((64'(k) * 64'd16) << 30) / EXP_TABLE_DEPTH;
    assign exp_rom[k] = exp_entry(Y);
  end

  logic [7:1] v_r;
  logic [7:1] en;
  logic       fire;

  always_comb begin
    en[7] = !v_r[7] || out_ch.ready;
    for (int i = 6; i >= 1; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign in_ch.ready = en[1] && !busy;
  assign fire        = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[1]) v_r[1] <= fire;
      for (int i = 2; i <= 7; i++) begin
        if (en[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  // stage 0: gravity, age step, damping exponent
  logic [24:0]        age_sum0;
  logic [23:0]        nage0;
  logic [47:0]        x0;
  logic signed [43:0] acc_prod0;
  logic signed [43:0] acc_rnd0;
  logic signed [44:0] vsum0;
  logic [31:0]        nv0;

  assign age_sum0  = {1'b0, in_ch.age} + 25'(DT_Q16);
  assign nage0     = age_sum0[24] ? 24'hFFFFFF : age_sum0[23:0];
  assign x0        = 48'(cfg.slowdown_rate) * 48'(in_ch.age);
  assign acc_prod0 = 44'(cfg.net_accel) * $signed(44'(DT_Q16));
  assign acc_rnd0  = (acc_prod0 + 44'sd32768) >>> 16;
  assign vsum0     = 45'(in_ch.vel_z) - 45'(acc_rnd0);
  assign nv0       = sat32(64'(vsum0));

  logic signed [31:0] px1_r, py1_r, pz1_r, nv1_r;
  logic [23:0]        nage1_r;
  logic [47:0]        x1_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      px1_r   <= in_ch.pos_x;
      py1_r   <= in_ch.pos_y;
      pz1_r   <= in_ch.pos_z;
      nv1_r   <= nv0;
      nage1_r <= nage0;
      x1_r    <= x0;
    end
  end

  // stage 1: table index scaling, life check, life ratio partial products
  logic [KX_W-1:0] kx1;
  logic            alive1;
  logic [47:0]     plo1;
  logic [40:0]     phi1;

  assign kx1    = KX_W'(x1_r) * K_DEPTH;
  assign alive1 = nage1_r < cfg.lifespan;
  assign plo1   = 48'(nage1_r) * 48'(cfg.recip_life[23:0]);
  assign phi1   = 41'(nage1_r) * 41'(cfg.recip_life[40:24]);

  logic signed [31:0] px2_r, py2_r, pz2_r, nv2_r;
  logic [23:0]        nage2_r;
  logic [KX_W-1:0]    kx2_r;
  logic               alive2_r;
  logic [47:0]        plo2_r;
  logic [40:0]        phi2_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      px2_r    <= px1_r;
      py2_r    <= py1_r;
      pz2_r    <= pz1_r;
      nv2_r    <= nv1_r;
      nage2_r  <= nage1_r;
      kx2_r    <= kx1;
      alive2_r <= alive1;
      plo2_r   <= plo1;
      phi2_r   <= phi1;
    end
  end

  // stage 2: damping lookup, relative life
  logic [KX_W-1:0] ksum2;
  logic [KX_W-1:0] kfull2;
  logic [16:0]     m2;
  logic [64:0]     rl_sum2;
  logic [16:0]     rlife2;

  assign ksum2   = kx2_r + K_HALF;
  assign kfull2  = ksum2 >> 36;
  assign rl_sum2 = 65'(plo2_r) + (65'(phi2_r) << 24);
  assign rlife2  = alive2_r ? rl_sum2[40:24] : 17'(Q_ONE);

  always_comb begin
    if (cfg.slowdown_rate == 24'd0) begin
      m2 = 17'(Q_ONE);
    end else if (kfull2 < K_DEPTH) begin
      m2 = exp_rom[kfull2[IDX_W-1:0]];
    end else begin
      m2 = 17'd0;
    end
  end

  logic signed [31:0] px3_r, py3_r, pz3_r, nv3_r;
  logic [23:0]        nage3_r;
  logic               alive3_r;
  logic [16:0]        m3_r;
  logic [16:0]        rlife3_r;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      px3_r    <= px2_r;
      py3_r    <= py2_r;
      pz3_r    <= pz2_r;
      nv3_r    <= nv2_r;
      nage3_r  <= nage2_r;
      alive3_r <= alive2_r;
      m3_r     <= m2;
      rlife3_r <= rlife2;
    end
  end

  // stage 3: damped velocity, ramp segment scaling
  logic signed [49:0] nvm3;
  logic               lo3;
  logic [16:0]        opnd3;
  logic [32:0]        rsel3;
  logic [49:0]        tprod3;

  assign nvm3   = 50'(nv3_r) * 50'($signed({1'b0, m3_r}));
  assign lo3    = rlife3_r <= {1'b0, cfg.ramp_mid};
  assign opnd3  = lo3 ? rlife3_r : rlife3_r - {1'b0, cfg.ramp_mid};
  assign rsel3  = lo3 ? cfg.recip_mid : cfg.recip_rest;
  assign tprod3 = 50'(opnd3) * 50'(rsel3);

  logic signed [31:0] px4_r, py4_r, pz4_r, nv4_r;
  logic [23:0]        nage4_r;
  logic               alive4_r;
  logic signed [49:0] nvm4_r;
  logic               lo4_r;
  logic [49:0]        tprod4_r;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      px4_r    <= px3_r;
      py4_r    <= py3_r;
      pz4_r    <= pz3_r;
      nv4_r    <= nv3_r;
      nage4_r  <= nage3_r;
      alive4_r <= alive3_r;
      nvm4_r   <= nvm3;
      lo4_r    <= lo3;
      tprod4_r <= tprod3;
    end
  end

  // stage 4: position step, ramp fraction clamp
  logic signed [60:0] nvmd4;
  logic [49:0]        tsh4;
  logic [16:0]        t4;

  assign nvmd4 = 61'(nvm4_r) * $signed(61'(DT_Q16));
  assign tsh4  = tprod4_r >> 16;
  assign t4    = (tsh4 > 50'(Q_ONE)) ? 17'(Q_ONE) : tsh4[16:0];

  logic signed [31:0] px5_r, py5_r, pz5_r, nv5_r;
  logic [23:0]        nage5_r;
  logic               alive5_r;
  logic signed [60:0] nvmd5_r;
  logic               lo5_r;
  logic [16:0]        t5_r;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      px5_r    <= px4_r;
      py5_r    <= py4_r;
      pz5_r    <= pz4_r;
      nv5_r    <= nv4_r;
      nage5_r  <= nage4_r;
      alive5_r <= alive4_r;
      nvmd5_r  <= nvmd4;
      lo5_r    <= lo4_r;
      t5_r     <= t4;
    end
  end

  // stage 5: new z position, ramp products
  logic signed [60:0] pz_rnd5;
  logic signed [61:0] pzs5;
  logic [31:0]        np5;
  logic [15:0]        pa5 [5];
  logic [15:0]        pb5 [5];
  logic [15:0]        pc5 [5];
  logic [15:0]        base5 [5];
  logic [15:0]        hi5 [5];
  logic signed [16:0] dlt5 [5];
  logic signed [34:0] prod5 [5];

  assign pz_rnd5 = (nvmd5_r + $signed(61'(64'd1 << 31))) >>> 32;
  assign pzs5    = 62'(pz5_r) + 62'(pz_rnd5);
  assign np5     = sat32(64'(pzs5));

  always_comb begin
    pa5[0] = cfg.size_points[15:0];
    pb5[0] = cfg.size_points[31:16];
    pc5[0] = cfg.size_points[47:32];
    for (int c = 1; c < 5; c++) begin
      pa5[c] = {8'd0, cfg.color_start[32-8*c +: 8]};
      pb5[c] = {8'd0, cfg.color_mid[32-8*c +: 8]};
      pc5[c] = {8'd0, cfg.color_end[32-8*c +: 8]};
    end
  end

  always_comb begin
    for (int c = 0; c < 5; c++) begin
      base5[c] = lo5_r ? pa5[c] : pb5[c];
      hi5[c]   = lo5_r ? pb5[c] : pc5[c];
      dlt5[c]  = $signed({1'b0, hi5[c]}) - $signed({1'b0, base5[c]});
      prod5[c] = 35'(dlt5[c]) * 35'($signed({1'b0, t5_r}));
    end
  end

  logic signed [31:0] px6_r, py6_r, np6_r, nv6_r;
  logic [23:0]        nage6_r;
  logic               alive6_r;
  logic [15:0]        base6_r [5];
  logic signed [34:0] prod6_r [5];

  always_ff @(posedge clk) begin
    if (en[6]) begin
      px6_r    <= px5_r;
      py6_r    <= py5_r;
      np6_r    <= np5;
      nv6_r    <= nv5_r;
      nage6_r  <= nage5_r;
      alive6_r <= alive5_r;
      for (int c = 0; c < 5; c++) begin
        base6_r[c] <= base5[c];
        prod6_r[c] <= prod5[c];
      end
    end
  end

  // stage 6: ramp sums
  logic signed [35:0] val6 [5];

  always_comb begin
    for (int c = 0; c < 5; c++) begin
      val6[c] = 36'($signed({1'b0, base6_r[c]})) + 36'((prod6_r[c] + 35'sd32768) >>> 16);
    end
  end

  logic signed [31:0] px7_r, py7_r, np7_r, nv7_r;
  logic [23:0]        nage7_r;
  logic               alive7_r;
  logic [15:0]        size7_r;
  logic [7:0]         red7_r, green7_r, blue7_r, alpha7_r;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      px7_r    <= px6_r;
      py7_r    <= py6_r;
      np7_r    <= np6_r;
      nv7_r    <= nv6_r;
      nage7_r  <= nage6_r;
      alive7_r <= alive6_r;
      size7_r  <= val6[0][15:0];
      red7_r   <= val6[1][7:0];
      green7_r <= val6[2][7:0];
      blue7_r  <= val6[3][7:0];
      alpha7_r <= val6[4][7:0];
    end
  end

  assign out_ch.valid     = v_r[7];
  assign out_ch.new_pos_x = px7_r;
  assign out_ch.new_pos_y = py7_r;
  assign out_ch.new_pos_z = np7_r;
  assign out_ch.new_vel_z = nv7_r;
  assign out_ch.new_age   = nage7_r;
  assign out_ch.size      = size7_r;
  assign out_ch.red       = red7_r;
  assign out_ch.green     = green7_r;
  assign out_ch.blue      = blue7_r;
  assign out_ch.alpha     = alpha7_r;
  assign out_ch.alive     = alive7_r;

`ifndef SYNTHESIS
  a_busy_block: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_ch.ready)
    else $error("word accepted while reciprocals recompute");
  a_damp_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[3] |-> m3_r <= 17'(Q_ONE))
    else $error("damping factor above one");
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[2] && !en[2] |=> v_r[2] && $stable(kx2_r) && $stable(nv2_r))
    else $error("stalled stage changed");
`endif

endmodule
`default_nettype wire
